### rtl/prim_mst_pkg.sv
// Shared constants, types and helpers of the minimum spanning tree unit.
// No dependencies; used by prim_minimum_spanning_tree_unit and its checker.
package prim_mst_pkg;

  localparam int DEFAULT_MAX_VERTICES = 64;

  localparam int WEIGHT_W = 14;
  localparam int TOTAL_W  = 20;
  localparam int INDEX_W  = 6;
  localparam int VCOUNT_W = 7;

  localparam logic [WEIGHT_W-1:0] NO_EDGE = 14'd9999;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd2;
  localparam logic [VCOUNT_W-1:0] VCOUNT_MIN   = 7'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_COST,
    S_EMIT
  } state_t;

  // Map a raw stored weight to a cost: zero and anything at or above infinity mean no edge
  function automatic logic [WEIGHT_W-1:0] edge_cost(input logic [WEIGHT_W-1:0] w);
    logic [WEIGHT_W-1:0] c;
    if (w == '0 || w >= NO_EDGE) begin
      c = NO_EDGE;
    end else begin
      c = w;
    end
    return c;
  endfunction

endpackage

### rtl/prim_mst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module prim_mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry and read one entry, with registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/prim_minimum_spanning_tree_unit.sv
// Top level of the minimum spanning tree unit (Prim's method, adjacency matrix).
// Depends on prim_mst_pkg and prim_mst_ram.
//
// A load item (func 0) writes one adjacency entry and never raises busy. A run
// item (func 1) grows a tree from vertex 0 over n vertices, n being vertex_count
// held to 2..MAX_VERTICES. Each of the n - 1 tree edges takes a sweep over the
// per-vertex memory that relaxes from the last vertex added (from row 0 on the
// first sweep) and finds the next nearest one, a read of the cost entry and a
// step to form the edge, which shows on the cycle after; the pace is set by the
// single read port of the per-vertex memory. Each edge appears for exactly one
// cycle with strobe high and the receiver cannot stall it; the last one has
// last_edge set, and a graph that falls apart ends with one item flagged
// disconnected. busy is low again in the cycle of the final strobe.
module prim_minimum_spanning_tree_unit #(
  parameter int MAX_VERTICES = prim_mst_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func,
  input  logic [prim_mst_pkg::INDEX_W-1:0]    row,
  input  logic [prim_mst_pkg::INDEX_W-1:0]    col,
  input  logic [prim_mst_pkg::WEIGHT_W-1:0]   weight,
  input  logic                                cfg_we,
  input  logic [prim_mst_pkg::VCOUNT_W-1:0]   cfg_wdata,
  output logic                                strobe,
  output logic [prim_mst_pkg::INDEX_W-1:0]    edge_parent,
  output logic [prim_mst_pkg::INDEX_W-1:0]    edge_vertex,
  output logic [prim_mst_pkg::WEIGHT_W-1:0]   edge_weight,
  output logic [prim_mst_pkg::TOTAL_W-1:0]    tree_cost,
  output logic                                last_edge,
  output logic                                disconnected
);

  localparam int VW        = $clog2(MAX_VERTICES);
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int ADJ_AW    = 2 * VW;
  localparam int ADJ_DEPTH = 1 << ADJ_AW;
  localparam int WW        = prim_mst_pkg::WEIGHT_W;
  localparam int VE_W      = WW + VW + 1;

  // Control state
  prim_mst_pkg::state_t state, state_next;
  logic [prim_mst_pkg::VCOUNT_W-1:0] vertex_count;
  logic                              rb_valid;

  // Run registers
  logic [CNT_W-1:0]                  n_run;
  logic [CNT_W-1:0]                  issue_i;
  logic [CNT_W-1:0]                  k;
  logic [VW-1:0]                     rb_idx;
  logic                              init_sweep;
  logic [VW-1:0]                     pick_prev;
  logic [VW-1:0]                     pick;
  logic [VW-1:0]                     par;
  logic [WW-1:0]                     dmin;
  logic                              found;
  logic [prim_mst_pkg::TOTAL_W-1:0]  total;

  // Memory ports
  logic                              adj_we;
  logic [ADJ_AW-1:0]                 adj_waddr;
  logic [ADJ_AW-1:0]                 adj_raddr;
  logic [WW-1:0]                     adj_rdata;
  logic [VE_W-1:0]                   vert_wdata;
  logic [VE_W-1:0]                   vert_rdata;

  // Combinational helpers
  logic                              run_start;
  logic                              issue_more;
  logic                              last_step;
  logic [CNT_W-1:0]                  n_clamped;
  logic [WW-1:0]                     adj_cost;
  logic [WW-1:0]                     ent_dist;
  logic [VW-1:0]                     ent_par;
  logic                              ent_tree;
  logic [WW-1:0]                     new_dist;
  logic [VW-1:0]                     new_par;
  logic                              new_tree;
  logic                              cand;
  logic [prim_mst_pkg::TOTAL_W-1:0]  total_next;

  assign busy       = (state != prim_mst_pkg::S_IDLE);
  assign run_start  = start && !busy && (func == prim_mst_pkg::FUNC_RUN);
  assign issue_more = (issue_i != n_run);
  assign last_step  = (CNT_W'(k + 1'b1) == n_run);

  // Hold the vertex count inside its legal range
  always_comb begin
    priority if (vertex_count < prim_mst_pkg::VCOUNT_MIN) begin
      n_clamped = CNT_W'(prim_mst_pkg::VCOUNT_MIN);
    end else if (vertex_count > prim_mst_pkg::VCOUNT_W'(MAX_VERTICES)) begin
      n_clamped = CNT_W'(MAX_VERTICES);
    end else begin
      n_clamped = CNT_W'(vertex_count);
    end
  end

  // Load port: drop writes that fall outside the stored matrix
  assign adj_we    = start && !busy && (func == prim_mst_pkg::FUNC_LOAD) &&
                     (7'(row) < 7'(MAX_VERTICES)) && (7'(col) < 7'(MAX_VERTICES));
  assign adj_waddr = {row[VW-1:0], col[VW-1:0]};

  // Read row 0 on the first sweep, the column of the last vertex added after it,
  // and the tree edge entry once a sweep is done
  always_comb begin
    if (state == prim_mst_pkg::S_COST) begin
      adj_raddr = {par, pick};
    end else if (init_sweep) begin
      adj_raddr = {VW'(0), issue_i[VW-1:0]};
    end else begin
      adj_raddr = {issue_i[VW-1:0], pick_prev};
    end
  end

  prim_mst_ram #(
    .WIDTH (WW),
    .DEPTH (ADJ_DEPTH)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (weight),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  prim_mst_ram #(
    .WIDTH (VE_W),
    .DEPTH (MAX_VERTICES)
  ) u_vert_ram (
    .clk   (clk),
    .we    (rb_valid),
    .waddr (rb_idx),
    .wdata (vert_wdata),
    .raddr (issue_i[VW-1:0]),
    .rdata (vert_rdata)
  );

  // Relax the vertex that came back from memory and test it against the running minimum
  assign adj_cost = prim_mst_pkg::edge_cost(adj_rdata);
  assign {ent_tree, ent_par, ent_dist} = vert_rdata;

  always_comb begin
    new_dist = ent_dist;
    new_par  = ent_par;
    new_tree = ent_tree;
    if (init_sweep) begin
      new_dist = adj_cost;
      new_par  = '0;
      new_tree = 1'b0;
    end else if (rb_idx == pick_prev) begin
      new_tree = 1'b1;
    end else if (!ent_tree && adj_cost < ent_dist) begin
      new_dist = adj_cost;
      new_par  = pick_prev;
    end
  end

  assign vert_wdata = {new_tree, new_par, new_dist};
  assign cand       = rb_valid && !new_tree && (new_dist < dmin);
  assign total_next = total + prim_mst_pkg::TOTAL_W'(adj_cost);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      prim_mst_pkg::S_IDLE: begin
        if (run_start) begin
          state_next = prim_mst_pkg::S_SWEEP;
        end
      end
      prim_mst_pkg::S_SWEEP: begin
        if (!issue_more && !rb_valid) begin
          state_next = prim_mst_pkg::S_COST;
        end
      end
      prim_mst_pkg::S_COST: begin
        state_next = prim_mst_pkg::S_EMIT;
      end
      prim_mst_pkg::S_EMIT: begin
        if (!found || last_step) begin
          state_next = prim_mst_pkg::S_IDLE;
        end else begin
          state_next = prim_mst_pkg::S_SWEEP;
        end
      end
      default: begin
        state_next = prim_mst_pkg::S_IDLE;
      end
    endcase
  end

  // State register, config register and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= prim_mst_pkg::S_IDLE;
      vertex_count <= prim_mst_pkg::VCOUNT_RESET;
      rb_valid     <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      state    <= state_next;
      rb_valid <= (state == prim_mst_pkg::S_SWEEP) && issue_more;
      strobe   <= (state == prim_mst_pkg::S_EMIT);
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
    end
  end

  // Run datapath
  always_ff @(posedge clk) begin
    rb_idx <= issue_i[VW-1:0];
    if (state == prim_mst_pkg::S_SWEEP && issue_more) begin
      issue_i <= CNT_W'(issue_i + 1'b1);
    end
    if (cand) begin
      dmin  <= new_dist;
      pick  <= rb_idx;
      par   <= new_par;
      found <= 1'b1;
    end
    if (run_start) begin
      n_run      <= n_clamped;
      init_sweep <= 1'b1;
      issue_i    <= CNT_W'(1);
      pick_prev  <= '0;
      dmin       <= prim_mst_pkg::NO_EDGE;
      found      <= 1'b0;
      total      <= '0;
      k          <= CNT_W'(1);
    end
    if (state == prim_mst_pkg::S_EMIT) begin
      if (found) begin
        edge_parent  <= prim_mst_pkg::INDEX_W'(par);
        edge_vertex  <= prim_mst_pkg::INDEX_W'(pick);
        edge_weight  <= dmin;
        tree_cost    <= total_next;
        last_edge    <= last_step;
        disconnected <= 1'b0;
        total        <= total_next;
      end else begin
        edge_parent  <= '0;
        edge_vertex  <= '0;
        edge_weight  <= '0;
        tree_cost    <= total;
        last_edge    <= 1'b1;
        disconnected <= 1'b1;
      end
      // Advance to the next sweep, relaxing from the vertex just added
      pick_prev  <= pick;
      init_sweep <= 1'b0;
      issue_i    <= CNT_W'(1);
      dmin       <= prim_mst_pkg::NO_EDGE;
      found      <= 1'b0;
      k          <= CNT_W'(k + 1'b1);
    end
  end

endmodule

### rtl/prim_mst_checker.sv
// Port-level checks of prim_minimum_spanning_tree_unit, attached by bind.
// Depends on prim_mst_pkg for field widths.
module prim_mst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              func,
  input logic                              strobe,
  input logic [prim_mst_pkg::INDEX_W-1:0]  edge_parent,
  input logic [prim_mst_pkg::INDEX_W-1:0]  edge_vertex,
  input logic [prim_mst_pkg::WEIGHT_W-1:0] edge_weight,
  input logic                              last_edge,
  input logic                              disconnected
);

  // A run item raises busy on the next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == prim_mst_pkg::FUNC_RUN |=> busy)
    else $error("run item accepted but busy not raised");

  // A disconnected item ends the run
  a_disc_last: assert property (@(posedge clk) disable iff (rst)
    strobe && disconnected |-> last_edge)
    else $error("disconnected item without last_edge");

  // Edge fields are cleared on a disconnected item
  a_disc_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && disconnected |-> edge_parent == '0 && edge_vertex == '0 && edge_weight == '0)
    else $error("disconnected item carries edge fields");

  // The unit is free again when the last item shows
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last_edge |-> !busy)
    else $error("busy still high on the last item");

  // More items follow a non-final one, so the run keeps going
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_edge |=> busy)
    else $error("run stopped after a non-final item");

endmodule

bind prim_minimum_spanning_tree_unit prim_mst_checker u_prim_mst_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .func         (func),
  .strobe       (strobe),
  .edge_parent  (edge_parent),
  .edge_vertex  (edge_vertex),
  .edge_weight  (edge_weight),
  .last_edge    (last_edge),
  .disconnected (disconnected)
);
